### rtl/fpd_pkg.sv
// Shared constants, register codes and transaction types of the flying pixel detector.
`timescale 1ns / 1ps

package fpd_pkg;

   localparam int DEPTH_BITS        = 16;
   localparam int AMP_BITS          = 12;
   localparam int ENTRY_BITS        = DEPTH_BITS + AMP_BITS + 1;
   localparam int ROW_BITS          = 10;
   localparam int COL_OUT_BITS      = 10;
   localparam int CFG_SIZE_BITS     = 11;
   localparam int MIN_BITS          = 4;
   localparam int JUMP_BITS         = 16;
   localparam int RATIO_BITS        = 9;
   localparam int PROD_BITS         = RATIO_BITS + AMP_BITS;
   localparam int COUNT_BITS        = 4;
   localparam int MAX_HEIGHT        = 1024;
   localparam int MAX_WIDTH_DEFAULT = 1024;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_WIDTH  = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_HEIGHT = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIN_VALID    = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEPTH_JUMP   = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_AMP_RATIO    = 3'd4;

   localparam logic [CFG_SIZE_BITS-1:0] FRAME_WIDTH_RESET  = 11'd640;
   localparam logic [CFG_SIZE_BITS-1:0] FRAME_HEIGHT_RESET = 11'd480;
   localparam logic [MIN_BITS-1:0]      MIN_VALID_RESET    = 4'd3;
   localparam logic [JUMP_BITS-1:0]     DEPTH_JUMP_RESET   = 16'd100;
   localparam logic [RATIO_BITS-1:0]    AMP_RATIO_RESET    = 9'd128;

   typedef struct packed {
      logic [DEPTH_BITS-1:0] depth_mm;
      logic [AMP_BITS-1:0]   amp_level;
      logic                  conf_ok;
   } req_payload_type;

   typedef struct packed {
      logic                    is_flying;
      logic [ROW_BITS-1:0]     pixel_row;
      logic [COL_OUT_BITS-1:0] pixel_col;
      logic                    run_end;
      logic                    frame_end;
   } rsp_payload_type;

endpackage

### rtl/flying_pixel_detector_top.sv
// Flying pixel detector: line store memory, 3x3 window, result sequencer and judge pipeline.
`timescale 1ns / 1ps

// Pixels enter in raster order, one transaction per clock unless req_stall holds them, and
// each is written into a three-line store memory while the two lines above it are read at
// the same column. The columns read build a 3x3 window, from which a sequencer judges the
// pixels whose last neighbor has just arrived, one result per clock unless rsp_stall holds it.
// An item causes n (0 to 4) results, and the next enters the sequencer only as its last result
// issues: one result per item inside the frame, two at a row end, up to four on the last row.
// Items pass the first stage, the window, then selection, reduction and response registers. The
// line store holds three lines of MAX_WIDTH pixels and needs no clearing after reset.
module flying_pixel_detector_top
   import fpd_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_payload_type           req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_payload_type           rsp_payload,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int CW          = $clog2(MAX_WIDTH);
   localparam int WW          = (CW + 1 > CFG_SIZE_BITS) ? CW + 1 : CFG_SIZE_BITS;
   localparam int STORE_WORDS = 3 * MAX_WIDTH;
   localparam int AW          = $clog2(STORE_WORDS);
   localparam int PCW         = (CW > COL_OUT_BITS) ? CW : COL_OUT_BITS;

   typedef logic [ENTRY_BITS-1:0] entry_type;

   typedef struct packed {
      logic [ROW_BITS-1:0] row;
      logic [CW-1:0]       col;
      logic                row_zero;
      logic                row_one;
      logic                col_zero;
      logic                col_one;
   } item_tag_type;

   typedef struct packed {
      logic [ROW_BITS-1:0]     pixel_row;
      logic [COL_OUT_BITS-1:0] pixel_col;
      logic                    run_end;
      logic                    frame_end;
   } result_tag_type;

   function automatic logic [1:0] bank_up(input logic [1:0] bank);
      return (bank == 2'd2) ? 2'd0 : bank + 2'd1;
   endfunction

   function automatic logic [1:0] bank_down(input logic [1:0] bank);
      return (bank == 2'd0) ? 2'd2 : bank - 2'd1;
   endfunction

   function automatic logic [AW-1:0] bank_base(input logic [1:0] bank);
      logic [AW-1:0] base;
      case (bank)
         2'd0:    base = '0;
         2'd1:    base = AW'(MAX_WIDTH);
         default: base = AW'(2 * MAX_WIDTH);
      endcase
      return base;
   endfunction

   // Configuration registers.
   logic [CFG_SIZE_BITS-1:0] frame_width_ff;
   logic [CFG_SIZE_BITS-1:0] frame_height_ff;
   logic [MIN_BITS-1:0]      min_valid_ff;
   logic [JUMP_BITS-1:0]     depth_jump_ff;
   logic [RATIO_BITS-1:0]    amp_ratio_ff;
   logic                     csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
         min_valid_ff    <= MIN_VALID_RESET;
         depth_jump_ff   <= DEPTH_JUMP_RESET;
         amp_ratio_ff    <= AMP_RATIO_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_wdata[CFG_SIZE_BITS-1:0];
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_wdata[CFG_SIZE_BITS-1:0];
            CSR_MIN_VALID:    min_valid_ff    <= csr_wdata[MIN_BITS-1:0];
            CSR_DEPTH_JUMP:   depth_jump_ff   <= csr_wdata[JUMP_BITS-1:0];
            CSR_AMP_RATIO:    amp_ratio_ff    <= csr_wdata[RATIO_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Frame size as used, clamped to the supported range.
   logic [WW-1:0]            width_raw;
   logic [WW-1:0]            used_w;
   logic [CFG_SIZE_BITS-1:0] used_h;

   always_comb begin
      width_raw = WW'(frame_width_ff);
      if (frame_width_ff == '0) begin
         used_w = WW'(1);
      end else if (width_raw > WW'(MAX_WIDTH)) begin
         used_w = WW'(MAX_WIDTH);
      end else begin
         used_w = width_raw;
      end
      if (frame_height_ff == '0) begin
         used_h = CFG_SIZE_BITS'(1);
      end else if (frame_height_ff > CFG_SIZE_BITS'(MAX_HEIGHT)) begin
         used_h = CFG_SIZE_BITS'(MAX_HEIGHT);
      end else begin
         used_h = frame_height_ff;
      end
   end

   // Pipeline handshake signals.
   logic req_accept;
   logic s1_valid_ff, s1_valid_in;
   logic s2_free, xfer, issue, s2_busy;
   logic sel_valid_ff, sel_valid_in, sel_free;
   logic red_valid_ff, red_valid_in, red_free;
   logic rsp_valid_ff, rsp_valid_in, out_free;

   assign req_stall  = s1_valid_ff && !s2_free;
   assign req_accept = req_valid && !req_stall;

   // Input position tracking, with the wrap that a reduced frame size forces.
   logic [ROW_BITS-1:0] in_row_ff, in_row_in;
   logic [CW-1:0]       in_col_ff, in_col_in;
   logic [1:0]          bank_ff, bank_in;
   logic                col_wrap, row_wrap;
   logic [ROW_BITS:0]   row_pre, row_next;
   logic [1:0]          bank_pre, bank_cur;
   logic [ROW_BITS-1:0] ir;
   logic [CW-1:0]       ic;
   logic [WW-1:0]       col_next;
   logic                last_col, last_row;
   logic [3:0]          job_mask;

   always_comb begin
      col_wrap = WW'(in_col_ff) >= used_w;
      row_pre  = col_wrap ? {1'b0, in_row_ff} + 11'd1 : {1'b0, in_row_ff};
      bank_pre = col_wrap ? bank_up(bank_ff) : bank_ff;
      row_wrap = row_pre >= used_h;
      ir       = row_wrap ? '0 : row_pre[ROW_BITS-1:0];
      bank_cur = row_wrap ? 2'd0 : bank_pre;
      ic       = col_wrap ? '0 : in_col_ff;

      col_next = WW'(ic) + WW'(1);
      row_next = {1'b0, ir} + 11'd1;
      last_col = col_next >= used_w;
      last_row = row_next >= used_h;

      if (last_col) begin
         in_col_in = '0;
         in_row_in = last_row ? '0 : row_next[ROW_BITS-1:0];
         bank_in   = last_row ? 2'd0 : bank_up(bank_cur);
      end else begin
         in_col_in = col_next[CW-1:0];
         in_row_in = ir;
         bank_in   = bank_cur;
      end

      job_mask[0] = (ir != '0) && (ic != '0);
      job_mask[1] = (ir != '0) && last_col;
      job_mask[2] = last_row && (ic != '0);
      job_mask[3] = last_row && last_col;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_row_ff <= '0;
         in_col_ff <= '0;
         bank_ff   <= 2'd0;
      end else if (req_accept) begin
         in_row_ff <= in_row_in;
         in_col_ff <= in_col_in;
         bank_ff   <= bank_in;
      end
   end

   // Line store: the current line is written while the two lines above are read.
   entry_type     row_store_mem [STORE_WORDS];
   entry_type     new_entry;
   entry_type     rd_above2_ff;
   entry_type     rd_above1_ff;
   logic [AW-1:0] wr_addr, rd_above2_addr, rd_above1_addr;

   assign new_entry      = {req_payload.conf_ok, req_payload.amp_level, req_payload.depth_mm};
   assign wr_addr        = bank_base(bank_cur) + AW'(ic);
   assign rd_above2_addr = bank_base(bank_up(bank_cur)) + AW'(ic);
   assign rd_above1_addr = bank_base(bank_down(bank_cur)) + AW'(ic);

   always_ff @(posedge clock) begin
      if (req_accept) begin
         row_store_mem[wr_addr] <= new_entry;
         rd_above2_ff           <= row_store_mem[rd_above2_addr];
         rd_above1_ff           <= row_store_mem[rd_above1_addr];
      end
   end

   // First stage: the accepted pixel waits for its column of the lines above.
   entry_type    s1_entry_ff;
   item_tag_type s1_tag_ff;
   logic [3:0]   s1_jobs_ff;

   assign s1_valid_in = req_accept ? 1'b1 : (xfer ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_entry_ff        <= new_entry;
         s1_tag_ff.row      <= ir;
         s1_tag_ff.col      <= ic;
         s1_tag_ff.row_zero <= (ir == '0);
         s1_tag_ff.row_one  <= (ir == ROW_BITS'(1));
         s1_tag_ff.col_zero <= (ic == '0);
         s1_tag_ff.col_one  <= (ic == CW'(1));
         s1_jobs_ff         <= job_mask;
      end
   end

   // Window of rows ir-2..ir and columns ic-2..ic, and the result sequencer.
   entry_type    win_ff [3][3];
   item_tag_type s2_tag_ff;
   logic [3:0]   s2_jobs_ff, s2_jobs_in;
   logic [3:0]   job_onehot, jobs_left;
   logic [1:0]   job_idx;

   always_comb begin
      job_onehot = s2_jobs_ff & (~s2_jobs_ff + 4'd1);
      jobs_left  = s2_jobs_ff & ~job_onehot;
      if (s2_jobs_ff[0]) begin
         job_idx = 2'd0;
      end else if (s2_jobs_ff[1]) begin
         job_idx = 2'd1;
      end else if (s2_jobs_ff[2]) begin
         job_idx = 2'd2;
      end else begin
         job_idx = 2'd3;
      end
      s2_busy = s2_jobs_ff != '0;
      issue   = s2_busy && sel_free;
      s2_free = !s2_busy || (sel_free && (jobs_left == '0));
      xfer    = s1_valid_ff && s2_free;
      if (xfer) begin
         s2_jobs_in = s1_jobs_ff;
      end else if (issue) begin
         s2_jobs_in = jobs_left;
      end else begin
         s2_jobs_in = s2_jobs_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (xfer) begin
         for (int r = 0; r < 3; r++) begin
            win_ff[r][0] <= win_ff[r][1];
            win_ff[r][1] <= win_ff[r][2];
         end
         win_ff[0][2] <= rd_above2_ff;
         win_ff[1][2] <= rd_above1_ff;
         win_ff[2][2] <= s1_entry_ff;
         s2_tag_ff    <= s1_tag_ff;
      end
   end

   // Neighbor selection for the centre chosen by the sequencer.
   entry_type             grid [4][4];
   logic [1:0]            cr, cc, wr, wc;
   logic                  edge_top, edge_bot, edge_left, edge_right;
   logic                  nb_ok [3][3];
   logic [DEPTH_BITS-1:0] nb_depth [3][3];
   logic [AMP_BITS-1:0]   nb_amp [3][3];
   logic [AMP_BITS-1:0]   centre_amp;
   result_tag_type        sel_tag;
   logic [PCW-1:0]        col_ext;
   entry_type             nb_entry;

   always_comb begin
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            grid[r][c] = '0;
         end
      end
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            grid[r][c] = win_ff[r][c];
         end
      end
      cr         = job_idx[1] ? 2'd2 : 2'd1;
      cc         = job_idx[0] ? 2'd2 : 2'd1;
      edge_top   = job_idx[1] ? s2_tag_ff.row_zero : s2_tag_ff.row_one;
      edge_bot   = job_idx[1];
      edge_left  = job_idx[0] ? s2_tag_ff.col_zero : s2_tag_ff.col_one;
      edge_right = job_idx[0];
      wr         = '0;
      wc         = '0;
      nb_entry   = '0;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            wr             = cr + 2'(i) - 2'd1;
            wc             = cc + 2'(j) - 2'd1;
            nb_entry       = grid[wr][wc];
            nb_ok[i][j]    = !(i == 1 && j == 1) && !(i == 0 && edge_top) &&
                             !(i == 2 && edge_bot) && !(j == 0 && edge_left) &&
                             !(j == 2 && edge_right) && nb_entry[ENTRY_BITS-1];
            nb_depth[i][j] = nb_entry[DEPTH_BITS-1:0];
            nb_amp[i][j]   = nb_entry[DEPTH_BITS +: AMP_BITS];
         end
      end
      centre_amp = grid[cr][cc][DEPTH_BITS +: AMP_BITS];

      sel_tag.pixel_row = job_idx[1] ? s2_tag_ff.row : s2_tag_ff.row - ROW_BITS'(1);
      col_ext           = PCW'(job_idx[0] ? s2_tag_ff.col : s2_tag_ff.col - CW'(1));
      sel_tag.pixel_col = col_ext[COL_OUT_BITS-1:0];
      sel_tag.run_end   = jobs_left == '0;
      sel_tag.frame_end = job_idx == 2'd3;
   end

   logic                  sel_ok_ff [3][3];
   logic [DEPTH_BITS-1:0] sel_depth_ff [3][3];
   logic [AMP_BITS-1:0]   sel_amp_ff [3][3];
   logic [AMP_BITS-1:0]   sel_centre_ff;
   result_tag_type        sel_tag_ff;

   assign sel_valid_in = sel_free ? s2_busy : sel_valid_ff;

   always_ff @(posedge clock) begin
      if (issue) begin
         sel_ok_ff     <= nb_ok;
         sel_depth_ff  <= nb_depth;
         sel_amp_ff    <= nb_amp;
         sel_centre_ff <= centre_amp;
         sel_tag_ff    <= sel_tag;
      end
   end

   // Reduction over the valid neighbors.
   logic [COUNT_BITS-1:0] cnt;
   logic [DEPTH_BITS-1:0] dmin, dmax;
   logic [AMP_BITS-1:0]   amax;

   always_comb begin
      cnt  = '0;
      dmin = '1;
      dmax = '0;
      amax = '0;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            if (sel_ok_ff[i][j]) begin
               if (sel_depth_ff[i][j] < dmin) begin
                  dmin = sel_depth_ff[i][j];
               end
               if (sel_depth_ff[i][j] > dmax) begin
                  dmax = sel_depth_ff[i][j];
               end
               if (sel_amp_ff[i][j] > amax) begin
                  amax = sel_amp_ff[i][j];
               end
               cnt = cnt + COUNT_BITS'(1);
            end
         end
      end
   end

   logic [COUNT_BITS-1:0] red_count_ff;
   logic [DEPTH_BITS-1:0] red_dmin_ff, red_dmax_ff;
   logic [AMP_BITS-1:0]   red_amax_ff, red_centre_ff;
   result_tag_type        red_tag_ff;

   assign red_valid_in = red_free ? sel_valid_ff : red_valid_ff;

   always_ff @(posedge clock) begin
      if (red_free && sel_valid_ff) begin
         red_count_ff  <= cnt;
         red_dmin_ff   <= dmin;
         red_dmax_ff   <= dmax;
         red_amax_ff   <= amax;
         red_centre_ff <= sel_centre_ff;
         red_tag_ff    <= sel_tag_ff;
      end
   end

   // Final decision: neighbor count, depth span and amplitude ratio.
   logic [DEPTH_BITS-1:0] span;
   logic [PROD_BITS-1:0]  ratio_product, centre_scaled;
   logic                  flying;
   rsp_payload_type       rsp_payload_ff;

   always_comb begin
      span          = red_dmax_ff - red_dmin_ff;
      ratio_product = amp_ratio_ff * red_amax_ff;
      centre_scaled = PROD_BITS'({red_centre_ff, 8'd0});
      flying        = (red_count_ff >= min_valid_ff) && (red_count_ff != '0) &&
                      (span > depth_jump_ff) && (red_amax_ff != '0) &&
                      (centre_scaled < ratio_product);
   end

   assign rsp_valid_in = out_free ? red_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (out_free && red_valid_ff) begin
         rsp_payload_ff.is_flying <= flying;
         rsp_payload_ff.pixel_row <= red_tag_ff.pixel_row;
         rsp_payload_ff.pixel_col <= red_tag_ff.pixel_col;
         rsp_payload_ff.run_end   <= red_tag_ff.run_end;
         rsp_payload_ff.frame_end <= red_tag_ff.frame_end;
      end
   end

   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign red_free    = !red_valid_ff || out_free;
   assign sel_free    = !sel_valid_ff || red_free;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_jobs_ff   <= '0;
         sel_valid_ff <= 1'b0;
         red_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_jobs_ff   <= s2_jobs_in;
         sel_valid_ff <= sel_valid_in;
         red_valid_ff <= red_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // An accepted transaction always lands inside the frame as currently configured.
   assert property (@(posedge clock) disable iff (reset)
      req_accept |-> (WW'(ic) < used_w) && ({1'b0, ir} < used_h))
      else $error("Accepted pixel position lies outside the frame.");

   // A held pixel in the first stage is never overwritten by a new transaction.
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !xfer) |-> !req_accept)
      else $error("First stage overwritten while still occupied.");

   // At most eight neighbors can ever be counted.
   assert property (@(posedge clock) disable iff (reset)
      red_valid_ff |-> (red_count_ff <= COUNT_BITS'(8)))
      else $error("Neighbor count exceeds eight.");

   // A new item enters the sequencer only once the previous one issues its last result.
   assert property (@(posedge clock) disable iff (reset)
      (xfer && s2_busy) |-> (issue && (jobs_left == '0)))
      else $error("Sequencer reloaded with results still pending.");

endmodule
